@@ hdl/irmse_pkg.sv @@
// irmse_pkg: shared constants, command codes and controller/datapath interface types
// for the interpolated RMSE block. No dependencies.
package irmse_pkg;
	localparam int SIM_DEPTH = 1024;
	localparam int AW = $clog2(SIM_DEPTH);
	localparam int CW = AW + 1;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_REF = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_NOREF = 2'd3;

	typedef struct packed {
		logic latch;      // capture input word
		logic load;       // append sample to store
		logic set_full;
		logic set_range;
		logic rd_first;   // read entry 0
		logic rd_last;    // read entry n-1
		logic rd_idx;     // read entry at scan index
		logic cap_lo;     // capture read data as left point
		logic cap_hi;     // capture read data as right point
		logic cap_first;
		logic idx_inc;
		logic idx_clr;
		logic div_start;
		logic mul1;       // frac * diff
		logic mul2;       // error: sample minus interpolated value
		logic mul3;
		logic accum;
		logic sqrt_start;
		logic emit;
		logic clear;
	} irmse_cmd_t;

	typedef struct packed {
		logic short_series;
		logic outside;
		logic in_bracket;
		logic last_interval;
		logic zero_span;
		logic div_done;
		logic sqrt_done;
		logic full;
		logic no_report;  // status not ok
	} irmse_sts_t;
endpackage

@@ hdl/interpolated_rmse_top.sv @@
// While busy, a load stores the sample; a reference checks the range, scans the
// intervals and interpolates (48-step division, none on a zero span); finish runs a
// 64-step mean division and a 32-step root, or neither with an error status.
// Throughput is set by the linear scan through the store's single read port.
// The result strobe done is high for one cycle; the receiver cannot stall.
// Reset (arst_n low) clears counts, sum and flags; store contents stay undefined.
module interpolated_rmse_top import irmse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] command,
	input logic [31:0] sample_time,
	input logic signed [23:0] sample_value,
	output logic done,
	output logic [23:0] rmse_value,
	output logic [31:0] sample_count,
	output logic [1:0] status
);
	irmse_cmd_t cmd;
	irmse_sts_t sts;

	irmse_ctrl u_ctrl (.clk, .arst_n, .start, .command, .sts, .cmd, .busy, .done);
	irmse_datapath u_dp (.clk, .arst_n, .sample_time, .sample_value,
		.cmd, .sts, .rmse_value, .sample_count, .status);
endmodule

@@ hdl/irmse_datapath.sv @@
// irmse_datapath: sample store, scan compare, serial divider, interpolation,
// squared-error accumulator and serial square root. Depends on irmse_pkg.
module irmse_datapath import irmse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [31:0] sample_time,
	input logic signed [23:0] sample_value,
	input irmse_cmd_t cmd,
	output irmse_sts_t sts,
	output logic [23:0] rmse_value,
	output logic [31:0] sample_count,
	output logic [1:0] status
);
	logic [31:0] times_mem [SIM_DEPTH];
	logic signed [23:0] values_mem [SIM_DEPTH];
	logic [31:0] rd_t_q;
	logic signed [23:0] rd_v_q;

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] idx_q;
	logic [31:0] t_q;
	logic signed [23:0] v_q;
	logic [31:0] t0_q, t1_q, tfirst_q;
	logic signed [23:0] v0_q, v1_q;
	logic [63:0] sum_q;
	logic [31:0] rcnt_q;
	logic full_q, range_q;

	logic [AW-1:0] rd_addr;
	always_comb begin
		rd_addr = idx_q;
		if (cmd.rd_first)
			rd_addr = '0;
		else if (cmd.rd_last)
			rd_addr = AW'(cnt_q - CW'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !sts.full) begin
			times_mem[cnt_q[AW-1:0]] <= t_q;
			values_mem[cnt_q[AW-1:0]] <= v_q;
		end
		rd_t_q <= times_mem[rd_addr];
		rd_v_q <= values_mem[rd_addr];
	end

	// divider: quotient of (dt << 16) / span, restoring, one bit a cycle
	logic [47:0] dq_q;
	logic [32:0] drem_q;
	logic [5:0] dcnt_q;
	logic dbusy_q;
	logic [32:0] dtrial;
	assign dtrial = {drem_q[31:0], dq_q[47]} - {1'b0, t1_q - t0_q};

	// sqrt: two bits a cycle on the mean
	logic [63:0] sx_q, sres_q, sbit_q;
	logic sbusy_q;
	logic [63:0] ssum;
	assign ssum = sres_q + sbit_q;

	// division of sum by count for the mean: restoring, 64 steps
	logic [63:0] mq_q;
	logic [32:0] mrem_q;
	logic [6:0] mcnt_q;
	logic mbusy_q, mdone_q;
	logic [32:0] mtrial;
	assign mtrial = {mrem_q[31:0], mq_q[63]} - {1'b0, rcnt_q};

	logic signed [41:0] prod_s1;
	logic signed [24:0] diff;
	logic signed [25:0] interp;
	logic signed [26:0] err_q;
	logic [25:0] err_mag;
	logic [51:0] sq_s2;
	logic [64:0] nsum;
	assign diff = 25'(v1_q) - 25'(v0_q);
	// truncating division by 65536 toward zero
	logic signed [41:0] prod_adj;
	assign prod_adj = prod_s1 + (prod_s1[41] ? 42'sd65535 : 42'sd0);
	assign interp = 26'(v0_q) + 26'(prod_adj >>> 16);
	assign err_mag = err_q[26] ? 26'(-err_q) : err_q[25:0];
	assign nsum = {1'b0, sum_q} + {13'd0, sq_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; idx_q <= '0; sum_q <= '0; rcnt_q <= '0;
			full_q <= 1'b0; range_q <= 1'b0;
			dbusy_q <= 1'b0; sbusy_q <= 1'b0; mbusy_q <= 1'b0; mdone_q <= 1'b0;
			rmse_value <= '0; sample_count <= '0; status <= ST_OK;
		end else begin
			if (cmd.load) begin
				if (sts.full)
					full_q <= 1'b1;
				else
					cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.set_full) full_q <= 1'b1;
			if (cmd.set_range) range_q <= 1'b1;
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + AW'(1);
			if (cmd.accum) begin
				sum_q <= nsum[64] ? '1 : nsum[63:0];
				if (rcnt_q != '1) rcnt_q <= rcnt_q + 32'd1;
			end
			if (cmd.div_start) begin
				dq_q <= {t_q - t0_q, 16'd0};
				drem_q <= '0; dcnt_q <= 6'd48; dbusy_q <= 1'b1;
			end else if (dbusy_q) begin
				if (!dtrial[32]) begin
					drem_q <= dtrial; dq_q <= {dq_q[46:0], 1'b1};
				end else begin
					drem_q <= {drem_q[31:0], dq_q[47]}; dq_q <= {dq_q[46:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd1) dbusy_q <= 1'b0;
			end
			if (cmd.sqrt_start) begin
				mq_q <= sum_q; mrem_q <= '0; mcnt_q <= 7'd64; mbusy_q <= 1'b1;
			end else if (mbusy_q) begin
				if (!mtrial[32]) begin
					mrem_q <= mtrial; mq_q <= {mq_q[62:0], 1'b1};
				end else begin
					mrem_q <= {mrem_q[31:0], mq_q[63]}; mq_q <= {mq_q[62:0], 1'b0};
				end
				mcnt_q <= mcnt_q - 7'd1;
				if (mcnt_q == 7'd1) begin
					mbusy_q <= 1'b0; mdone_q <= 1'b1;
				end
			end else if (mdone_q) begin
				mdone_q <= 1'b0;
				sx_q <= mq_q; sres_q <= '0; sbit_q <= 64'd1 << 62; sbusy_q <= 1'b1;
			end else if (sbusy_q) begin
				if (sx_q >= ssum) begin
					sx_q <= sx_q - ssum;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				if (sbit_q[1:0] != 2'b00) sbusy_q <= 1'b0;
			end
			if (cmd.emit) begin
				sample_count <= rcnt_q;
				if (full_q) begin
					status <= ST_FULL; rmse_value <= '0;
				end else if (range_q) begin
					status <= ST_RANGE; rmse_value <= '0;
				end else if (rcnt_q == '0) begin
					status <= ST_NOREF; rmse_value <= '0;
				end else begin
					status <= ST_OK;
					rmse_value <= (sres_q[63:24] != '0) ? '1 : sres_q[23:0];
				end
			end
			if (cmd.clear) begin
				cnt_q <= '0; sum_q <= '0; rcnt_q <= '0;
				full_q <= 1'b0; range_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			t_q <= sample_time; v_q <= sample_value;
		end
		if (cmd.cap_first) tfirst_q <= rd_t_q;
		if (cmd.cap_lo) begin
			t0_q <= rd_t_q; v0_q <= rd_v_q;
		end
		if (cmd.cap_hi) begin
			t1_q <= rd_t_q; v1_q <= rd_v_q;
		end
		if (cmd.mul1) prod_s1 <= $signed({1'b0, dq_q[16:0]}) * diff;
		if (cmd.mul2) begin
			if (t1_q == t0_q)
				err_q <= 27'(v_q) - 27'(v0_q);
			else
				err_q <= 27'(v_q) - 27'(interp);
		end
		if (cmd.mul3) sq_s2 <= err_mag * err_mag;
	end

	assign sts.short_series = cnt_q < CW'(2);
	assign sts.outside = (t_q < tfirst_q) || (t_q > rd_t_q);
	assign sts.in_bracket = (t_q >= t0_q) && (t_q <= t1_q);
	// right endpoint at the last stored entry
	assign sts.last_interval = ({1'b0, idx_q} + CW'(1)) >= cnt_q;
	assign sts.zero_span = t1_q == t0_q;
	assign sts.div_done = !dbusy_q && !cmd.div_start;
	assign sts.sqrt_done = !sbusy_q && !mbusy_q && !mdone_q && !cmd.sqrt_start;
	assign sts.full = cnt_q == CW'(SIM_DEPTH);
	assign sts.no_report = full_q || range_q || (rcnt_q == '0);
endmodule

@@ hdl/irmse_ctrl.sv @@
// irmse_ctrl: sequencer for load, reference scan/interpolate/accumulate and
// finish/report. Depends on irmse_pkg.
module irmse_ctrl import irmse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] command,
	input irmse_sts_t sts,
	output irmse_cmd_t cmd,
	output logic busy,
	output logic done
);
	localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RDF = 4'd2, S_RDL = 4'd3,
		S_CHK = 4'd4, S_RDLO = 4'd5, S_RDHI = 4'd6, S_CAPHI = 4'd7, S_TEST = 4'd8,
		S_DIV = 4'd9, S_MUL1 = 4'd10, S_MUL2 = 4'd11, S_MUL3 = 4'd12, S_ACC = 4'd13,
		S_SQRT = 4'd14, S_EMIT = 4'd15;
	logic [3:0] st_q, st_d;
	logic [1:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; op_q <= CMD_LOAD; done <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= (st_q == S_EMIT);
			if (start && st_q == S_IDLE) op_q <= command;
		end
	end

	assign busy = st_q != S_IDLE;

	always_comb begin
		cmd = '0;
		st_d = st_q;
		unique case (st_q)
			S_IDLE: if (start) begin
				cmd.latch = 1'b1; st_d = S_DEC;
			end
			S_DEC: begin
				st_d = S_IDLE;
				if (op_q == CMD_LOAD) cmd.load = 1'b1;
				else if (op_q == CMD_REF) begin
					if (sts.short_series) cmd.set_range = 1'b1;
					else begin
						cmd.rd_first = 1'b1; st_d = S_RDF;
					end
				end else if (op_q == CMD_FINISH) begin
					if (sts.no_report) st_d = S_EMIT;
					else begin
						cmd.sqrt_start = 1'b1; st_d = S_SQRT;
					end
				end
			end
			S_RDF: begin
				// read data holds entry 0 here
				cmd.cap_first = 1'b1; cmd.rd_last = 1'b1; st_d = S_RDL;
			end
			S_RDL: begin
				// keep entry n-1 on the read port for the range check
				cmd.rd_last = 1'b1; cmd.idx_clr = 1'b1; st_d = S_CHK;
			end
			S_CHK: begin
				if (sts.outside) begin
					cmd.set_range = 1'b1; st_d = S_IDLE;
				end else begin
					cmd.rd_idx = 1'b1; st_d = S_RDLO;
				end
			end
			S_RDLO: begin
				cmd.cap_lo = 1'b1; cmd.idx_inc = 1'b1; st_d = S_RDHI;
			end
			S_RDHI: begin
				cmd.rd_idx = 1'b1; st_d = S_CAPHI;
			end
			S_CAPHI: begin
				cmd.cap_hi = 1'b1; st_d = S_TEST;
			end
			S_TEST: begin
				// idx already points at right endpoint
				if (sts.in_bracket) begin
					if (sts.zero_span) st_d = S_MUL2;
					else begin
						cmd.div_start = 1'b1; st_d = S_DIV;
					end
				end else if (sts.last_interval) begin
					cmd.set_range = 1'b1; st_d = S_IDLE;
				end else begin
					// slide window: right point becomes left
					cmd.rd_idx = 1'b1; st_d = S_RDLO;
				end
			end
			S_DIV: if (sts.div_done) st_d = S_MUL1;
			S_MUL1: begin
				cmd.mul1 = 1'b1; st_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1; st_d = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul3 = 1'b1; st_d = S_ACC;
			end
			S_ACC: begin
				cmd.accum = 1'b1; st_d = S_IDLE;
			end
			S_SQRT: if (sts.sqrt_done) st_d = S_EMIT;
			S_EMIT: begin
				cmd.emit = 1'b1; cmd.clear = 1'b1; st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end
endmodule

@@ hdl/irmse_checker.sv @@
// irmse_checker: port-level assertions for interpolated_rmse_top, bound to it.
// Depends on irmse_pkg.
module irmse_checker import irmse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [1:0] command,
	input logic done,
	input logic [23:0] rmse_value,
	input logic [1:0] status
);
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("word not taken");
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("strobe longer than a cycle");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> rmse_value == '0) else $error("root on error");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy during report");
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> !$isunknown(command)) else $error("unknown command");
endmodule

bind interpolated_rmse_top irmse_checker u_chk (.clk, .arst_n, .start, .busy, .command,
	.done, .rmse_value, .status);

@@ sim/interpolated_rmse_top_tb.sv @@
// Self-checking testbench for interpolated_rmse_top: drives load, reference, finish and
// unused words and checks each report against an internal RMSE predictor.
// Depends on irmse_pkg and the interpolated_rmse_top RTL.
module interpolated_rmse_top_tb;
	import irmse_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 40000;

	typedef struct {
		logic [23:0] rmse;
		logic [31:0] count;
		logic [1:0] stat;
	} report_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] command;
	logic [31:0] sample_time;
	logic signed [23:0] sample_value;
	logic done;
	logic [23:0] rmse_value;
	logic [31:0] sample_count;
	logic [1:0] status;

	interpolated_rmse_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .sample_time(sample_time), .sample_value(sample_value),
		.done(done), .rmse_value(rmse_value), .sample_count(sample_count),
		.status(status)
	);

	// predictor state
	logic [31:0] series_time [SIM_DEPTH];
	int series_value [SIM_DEPTH];
	int unsigned series_len;
	longint unsigned sq_err_sum;
	int unsigned ref_count;
	bit full_flag;
	bit range_flag;

	report_t pending_reports[$];
	int errors = 0;
	int idle_pct = 0;
	int watchdog = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned root = 0;
		longint unsigned rbit = 64'd1 << 62;
		while (rbit > x) rbit >>= 2;
		while (rbit != 0) begin
			if (x >= root + rbit) begin
				x -= root + rbit;
				root = (root >> 1) + rbit;
			end else begin
				root >>= 1;
			end
			rbit >>= 2;
		end
		return root;
	endfunction

	// first bracketing interval, linear interpolation with Q1.16 fraction
	function automatic bit interpolate(logic [31:0] t, output longint val);
		logic [31:0] t0, t1, span;
		longint frac, diff;
		val = 0;
		if (series_len < 2) return 0;
		if (t < series_time[0] || t > series_time[series_len-1]) return 0;
		for (int i = 0; i + 1 < series_len; i++) begin
			t0 = series_time[i];
			t1 = series_time[i+1];
			if (t >= t0 && t <= t1) begin
				span = t1 - t0;
				if (span == 0) begin
					val = series_value[i];
					return 1;
				end
				frac = longint'((longint'(t - t0) << 16) / longint'(span));
				diff = longint'(series_value[i+1]) - longint'(series_value[i]);
				val = longint'(series_value[i]) + (frac * diff) / 65536;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic void clear_model();
		series_len = 0;
		sq_err_sum = 0;
		ref_count = 0;
		full_flag = 0;
		range_flag = 0;
	endfunction

	function automatic void predict_word(logic [1:0] cmd, logic [31:0] t,
			logic signed [23:0] v);
		longint interp_val, err;
		longint unsigned sq;
		report_t rep;
		case (cmd)
			CMD_LOAD: begin
				if (series_len >= SIM_DEPTH) full_flag = 1;
				else begin
					series_time[series_len] = t;
					series_value[series_len] = int'(v);
					series_len++;
				end
			end
			CMD_REF: begin
				if (!interpolate(t, interp_val)) range_flag = 1;
				else begin
					err = longint'(v) - interp_val;
					if (err < 0) err = -err;
					sq = longint'(err) * longint'(err);
					if (sq_err_sum > 64'hFFFF_FFFF_FFFF_FFFF - sq)
						sq_err_sum = 64'hFFFF_FFFF_FFFF_FFFF;
					else
						sq_err_sum += sq;
					if (ref_count != 32'hFFFF_FFFF) ref_count++;
				end
			end
			CMD_FINISH: begin
				if (full_flag) rep.stat = ST_FULL;
				else if (range_flag) rep.stat = ST_RANGE;
				else if (ref_count == 0) rep.stat = ST_NOREF;
				else rep.stat = ST_OK;
				rep.rmse = 0;
				if (rep.stat == ST_OK) begin
					sq = int_sqrt(sq_err_sum / ref_count);
					rep.rmse = (sq > 24'hFFFFFF) ? 24'hFFFFFF : sq[23:0];
				end
				rep.count = ref_count;
				pending_reports = {pending_reports, rep};
				clear_model();
			end
			default: ;
		endcase
	endfunction

	// prediction on acceptance, checking on the done strobe, watchdog
	always @(posedge clk) begin
		report_t exp_rep;
		if (arst_n) begin
			if (start && !busy) predict_word(command, sample_time, sample_value);
			if (done) begin
				if (pending_reports.size() == 0) begin
					$display("%0t: unexpected report rmse=%0d count=%0d status=%0d",
						$time, rmse_value, sample_count, status);
					errors++;
				end else begin
					exp_rep = pending_reports.pop_front();
					if (rmse_value !== exp_rep.rmse) begin
						$display("%0t: rmse_value expected %0d actual %0d",
							$time, exp_rep.rmse, rmse_value);
						errors++;
					end
					if (sample_count !== exp_rep.count) begin
						$display("%0t: sample_count expected %0d actual %0d",
							$time, exp_rep.count, sample_count);
						errors++;
					end
					if (status !== exp_rep.stat) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_rep.stat, status);
						errors++;
					end
				end
			end
			if ((start && !busy) || done) watchdog <= 0;
			else watchdog <= watchdog + 1;
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// start is left high on return so back-to-back words need no new rising edge on it
	task automatic send_word(logic [1:0] cmd, logic [31:0] t, logic signed [23:0] v);
		int gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		command <= cmd;
		sample_time <= t;
		sample_value <= v;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		wait (pending_reports.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed();
		send_word(CMD_FINISH, 0, 0);               // nothing referenced
		send_word(CMD_LOAD, 5, 0);
		send_word(CMD_REF, 5, 0);                  // series too short
		send_word(CMD_FINISH, 0, 0);
		send_word(CMD_LOAD, 0, -24'sd8388608);
		send_word(CMD_LOAD, 100, 24'sd8388607);
		send_word(CMD_LOAD, 100, 24'sd1000);       // zero span
		send_word(CMD_LOAD, 32'hFFFF_FFFF, -24'sd8388608);
		send_word(CMD_REF, 0, 24'sd8388607);
		send_word(CMD_REF, 50, -24'sd8388608);
		send_word(CMD_REF, 100, 0);
		send_word(CMD_REF, 32'h8000_0000, 24'sd12345);
		send_word(CMD_REF, 32'hFFFF_FFFF, 24'sd8388607);
		send_word(CMD_UNUSED, 32'hFFFF_FFFF, -24'sd1);
		send_word(CMD_FINISH, 0, 0);
		send_word(CMD_LOAD, 10, 24'sd100);
		send_word(CMD_LOAD, 20, -24'sd100);
		send_word(CMD_REF, 15, 0);
		send_word(CMD_REF, 5, 0);                  // before first time
		send_word(CMD_REF, 25, 0);                 // after last time
		send_word(CMD_FINISH, 0, 0);
		drain();
	endtask

	// whole series with random content; a share of words are malformed
	task automatic test_random(int n_words, int pct);
		int sent = 0;
		int len, n_ref;
		logic [31:0] t, first_t, last_t;
		bit sorted;
		idle_pct = pct;
		while (sent < n_words) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 10);
			sorted = $urandom_range(0, 9) != 0;
			t = $urandom_range(0, 32'hF000_0000);
			if ($urandom_range(0, 7) == 0) t = $urandom;
			first_t = t;
			for (int i = 0; i < len; i++) begin
				send_word(CMD_LOAD, t, 24'($urandom_range(0, 24'hFFFFFF)));
				last_t = t;
				if (sorted) t = t + (($urandom_range(0, 3) == 0) ? 0 :
					(($urandom_range(0, 1) == 0) ? $urandom_range(1, 300) :
					$urandom_range(1, 1 << 20)));
				else t = $urandom;
				sent++;
			end
			n_ref = $urandom_range(0, 12);
			for (int i = 0; i < n_ref; i++) begin
				if (len >= 2 && sorted && $urandom_range(0, 9) != 0)
					t = first_t + $urandom_range(0, last_t - first_t);
				else
					t = $urandom;
				if ($urandom_range(0, 3) == 0)
					send_word(CMD_REF, t, 24'($urandom_range(0, 24'hFFFFFF)));
				else
					send_word(CMD_REF, t, 24'($urandom_range(0, 2000) - 1000));
				sent++;
			end
			if ($urandom_range(0, 15) == 0) send_word(CMD_UNUSED, $urandom, 24'($urandom));
			send_word(CMD_FINISH, $urandom, 24'($urandom));
			sent++;
		end
		drain();
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		command = CMD_LOAD;
		sample_time = 0;
		sample_value = 0;
		idle_pct = 15;
		clear_model();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(180, 15);
		test_random(180, 72);
		test_random(180, 0);
		start <= 0;
		wait (pending_reports.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_reports.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
